// ===== rtl/us_timer_with_four_alarms_assert.svh =====
// Assertion macros for the microsecond timer checker.
// Used by ustmr_checker.sv; depends on nothing else.
`ifndef US_TIMER_WITH_FOUR_ALARMS_ASSERT_SVH
`define US_TIMER_WITH_FOUR_ALARMS_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define USTMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer checker: same-cycle property failed");

// Next-cycle implication, disabled while in reset.
`define USTMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer checker: next-cycle property failed");

`endif

// ===== rtl/ustmr_pkg.sv =====
// Shared constants for the microsecond timer: command and alias codes,
// register offsets and field widths. No dependencies.
`default_nettype none

package ustmr_pkg;

    localparam int ALARM_COUNT_DEF = 4;
    localparam int ALARM_MAX       = 4;

    localparam int CMD_W  = 2;
    localparam int OFF_W  = 8;
    localparam int KIND_W = 2;
    localparam int WORD_W = 32;
    localparam int TIME_W = 64;
    localparam int IRQ_W  = 4;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IRQ_W-1:0]  irq_t;

    localparam cmd_t CMD_READ  = 2'd0;
    localparam cmd_t CMD_WRITE = 2'd1;
    localparam cmd_t CMD_TICK  = 2'd2;

    localparam kind_t ALIAS_PLAIN = 2'd0;
    localparam kind_t ALIAS_XOR   = 2'd1;
    localparam kind_t ALIAS_SET   = 2'd2;
    localparam kind_t ALIAS_CLR   = 2'd3;

    localparam off_t OFF_TIMEHW   = 8'h00;
    localparam off_t OFF_TIMELW   = 8'h04;
    localparam off_t OFF_TIMEHR   = 8'h08;
    localparam off_t OFF_TIMELR   = 8'h0C;
    localparam off_t OFF_ALARM0   = 8'h10;
    localparam off_t OFF_ARMED    = 8'h20;
    localparam off_t OFF_TIMERAWH = 8'h24;
    localparam off_t OFF_TIMERAWL = 8'h28;
    localparam off_t OFF_PAUSE    = 8'h30;
    localparam off_t OFF_INTR     = 8'h3C;
    localparam off_t OFF_INTE     = 8'h40;
    localparam off_t OFF_INTF     = 8'h44;
    localparam off_t OFF_INTS     = 8'h48;

    localparam int ALARM_STRIDE = 4;

endpackage

`default_nettype wire

// ===== rtl/us_timer_with_four_alarms.sv =====
// Microsecond timer with up to four alarm comparators behind a register window.
// Depends on ustmr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: a bus
//   read, a bus write (plain, XOR, SET or CLR alias) or a tick of tick_us
//   microseconds. Output channel (out_valid / out_stall) returns one result
//   item per input item, in order: rdata, irq_pulse, irq_level.
//   Pipeline: 2 register stages, input and result. An accepted item waits in
//   the input register until it fires, and its result goes to the result register.
//   Throughput: one item per cycle while no result is stalled. The figure is
//   set by the single state update stage, whose longest path is the 64-bit
//   tick add feeding the 32-bit alarm compares.
//   Stall: while out_stall holds a result, one more item is taken into the
//   input register; after that in_stall rises until the result is taken.
//   Reset: rst_n clears the count, alarm targets, masks, pause flag and both
//   stages; no item is held and in_stall is low out of reset.
`default_nettype none

module us_timer_with_four_alarms #(
    parameter int ALARM_COUNT = ustmr_pkg::ALARM_COUNT_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ustmr_pkg::cmd_t  cmd,
    input  wire ustmr_pkg::off_t  reg_offset,
    input  wire ustmr_pkg::kind_t alias_kind,
    input  wire ustmr_pkg::word_t wdata,
    input  wire ustmr_pkg::word_t tick_us,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output ustmr_pkg::word_t      rdata,
    output ustmr_pkg::irq_t       irq_pulse,
    output ustmr_pkg::irq_t       irq_level
);

    typedef logic [ALARM_COUNT-1:0] amask_t;

    // Input register
    logic                  in_valid_reg;
    ustmr_pkg::cmd_t       cmd_reg;
    ustmr_pkg::off_t       off_reg;
    ustmr_pkg::kind_t      kind_reg;
    ustmr_pkg::word_t      wdata_reg;
    ustmr_pkg::word_t      tick_reg;

    // Timer state
    logic [ustmr_pkg::TIME_W-1:0] time_reg,  time_next;
    ustmr_pkg::word_t             target_reg [ALARM_COUNT];
    ustmr_pkg::word_t             target_next [ALARM_COUNT];
    amask_t                       armed_reg, armed_next;
    amask_t                       raw_reg,   raw_next;
    amask_t                       inte_reg,  inte_next;
    amask_t                       intf_reg,  intf_next;
    logic                         paused_reg, paused_next;

    // Result register
    logic                  out_valid_reg;
    ustmr_pkg::word_t      rdata_reg;
    ustmr_pkg::irq_t       pulse_reg;
    ustmr_pkg::irq_t       level_reg;

    logic                  fire;
    logic                  accept;
    amask_t                alarm_hit;
    ustmr_pkg::word_t      rd_cur;
    ustmr_pkg::word_t      wr_val;
    amask_t                status_cur;
    amask_t                status_after;
    amask_t                pulse_next;
    ustmr_pkg::word_t      rdata_next;

    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign rdata     = rdata_reg;
    assign irq_pulse = pulse_reg;
    assign irq_level = level_reg;

    assign status_cur = (raw_reg | intf_reg) & inte_reg;

    always_comb
    begin
        for (int i = 0; i < ALARM_COUNT; i++)
        begin
            alarm_hit[i] = (off_reg == ustmr_pkg::off_t'(ustmr_pkg::OFF_ALARM0
                            + ustmr_pkg::ALARM_STRIDE * i));
        end
    end

    // Register read, shared by bus reads and aliased writes
    always_comb
    begin
        rd_cur = '0;
        case (off_reg)
            ustmr_pkg::OFF_TIMEHR:
                rd_cur = (|raw_reg) ? ustmr_pkg::word_t'(1)
                                    : time_reg[ustmr_pkg::TIME_W-1:ustmr_pkg::WORD_W];
            ustmr_pkg::OFF_TIMELR,
            ustmr_pkg::OFF_TIMERAWL: rd_cur = time_reg[ustmr_pkg::WORD_W-1:0];
            ustmr_pkg::OFF_TIMERAWH:
                rd_cur = time_reg[ustmr_pkg::TIME_W-1:ustmr_pkg::WORD_W];
            ustmr_pkg::OFF_ARMED:    rd_cur = ustmr_pkg::word_t'(armed_reg);
            ustmr_pkg::OFF_PAUSE:    rd_cur = ustmr_pkg::word_t'(paused_reg);
            ustmr_pkg::OFF_INTR:     rd_cur = ustmr_pkg::word_t'(raw_reg);
            ustmr_pkg::OFF_INTE:     rd_cur = ustmr_pkg::word_t'(inte_reg);
            ustmr_pkg::OFF_INTF:     rd_cur = ustmr_pkg::word_t'(intf_reg);
            ustmr_pkg::OFF_INTS:     rd_cur = ustmr_pkg::word_t'(status_cur);
            default:                 rd_cur = '0;
        endcase
        for (int i = 0; i < ALARM_COUNT; i++)
        begin
            if (alarm_hit[i])
            begin
                rd_cur = target_reg[i];
            end
        end
    end

    always_comb
    begin
        case (kind_reg)
            ustmr_pkg::ALIAS_XOR: wr_val = rd_cur ^ wdata_reg;
            ustmr_pkg::ALIAS_SET: wr_val = rd_cur | wdata_reg;
            ustmr_pkg::ALIAS_CLR: wr_val = rd_cur & ~wdata_reg;
            default:              wr_val = wdata_reg;
        endcase
    end

    // State update for the item in the input register
    always_comb
    begin
        logic [ustmr_pkg::TIME_W-1:0] sum;
        ustmr_pkg::word_t             diff;
        logic                         status_pulse;
        amask_t                       tick_pulse;

        time_next    = time_reg;
        armed_next   = armed_reg;
        raw_next     = raw_reg;
        inte_next    = inte_reg;
        intf_next    = intf_reg;
        paused_next  = paused_reg;
        status_pulse = 1'b0;
        tick_pulse   = '0;
        rdata_next   = '0;
        diff         = '0;
        sum          = time_reg + ustmr_pkg::TIME_W'(tick_reg);
        for (int i = 0; i < ALARM_COUNT; i++)
        begin
            target_next[i] = target_reg[i];
        end

        case (cmd_reg)
            ustmr_pkg::CMD_READ:
            begin
                rdata_next = rd_cur;
            end
            ustmr_pkg::CMD_WRITE:
            begin
                for (int i = 0; i < ALARM_COUNT; i++)
                begin
                    if (alarm_hit[i])
                    begin
                        target_next[i] = wr_val;
                        armed_next[i]  = 1'b1;
                    end
                end
                case (off_reg)
                    ustmr_pkg::OFF_TIMEHW:
                        time_next[ustmr_pkg::TIME_W-1:ustmr_pkg::WORD_W] = wr_val;
                    ustmr_pkg::OFF_TIMELW:
                        time_next[ustmr_pkg::WORD_W-1:0] = wr_val;
                    ustmr_pkg::OFF_ARMED:
                        armed_next = armed_reg & ~wr_val[ALARM_COUNT-1:0];
                    ustmr_pkg::OFF_PAUSE:
                        paused_next = wr_val[0];
                    ustmr_pkg::OFF_INTR:
                        raw_next = raw_reg & ~wr_val[ALARM_COUNT-1:0];
                    ustmr_pkg::OFF_INTE:
                    begin
                        inte_next    = wr_val[ALARM_COUNT-1:0];
                        status_pulse = 1'b1;
                    end
                    ustmr_pkg::OFF_INTF:
                    begin
                        intf_next    = wr_val[ALARM_COUNT-1:0];
                        status_pulse = 1'b1;
                    end
                    default:
                    begin
                        status_pulse = 1'b0;
                    end
                endcase
            end
            ustmr_pkg::CMD_TICK:
            begin
                if (!paused_reg && (tick_reg != '0))
                begin
                    time_next = sum;
                    for (int i = 0; i < ALARM_COUNT; i++)
                    begin
                        // fire when the wrapped difference is non-negative
                        diff = sum[ustmr_pkg::WORD_W-1:0] - target_reg[i];
                        if (armed_reg[i] && !diff[ustmr_pkg::WORD_W-1])
                        begin
                            raw_next[i]   = 1'b1;
                            armed_next[i] = 1'b0;
                            tick_pulse[i] = inte_reg[i];
                        end
                    end
                end
            end
            default:
            begin
                rdata_next = '0;
            end
        endcase

        status_after = (raw_next | intf_next) & inte_next;
        pulse_next   = status_pulse ? status_after : tick_pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            off_reg   <= reg_offset;
            kind_reg  <= alias_kind;
            wdata_reg <= wdata;
            tick_reg  <= tick_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg   <= '0;
            armed_reg  <= '0;
            raw_reg    <= '0;
            inte_reg   <= '0;
            intf_reg   <= '0;
            paused_reg <= 1'b0;
            for (int i = 0; i < ALARM_COUNT; i++)
            begin
                target_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            time_reg   <= time_next;
            armed_reg  <= armed_next;
            raw_reg    <= raw_next;
            inte_reg   <= inte_next;
            intf_reg   <= intf_next;
            paused_reg <= paused_next;
            for (int i = 0; i < ALARM_COUNT; i++)
            begin
                target_reg[i] <= target_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rdata_reg <= rdata_next;
            pulse_reg <= ustmr_pkg::irq_t'(pulse_next);
            level_reg <= ustmr_pkg::irq_t'(status_after);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ustmr_checker.sv =====
// Port-level checker for the microsecond timer, bound to the timer module.
// Depends on ustmr_pkg and us_timer_with_four_alarms_assert.svh.
`default_nettype none

`include "us_timer_with_four_alarms_assert.svh"

module ustmr_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire ustmr_pkg::word_t rdata,
    input wire ustmr_pkg::irq_t  irq_pulse,
    input wire ustmr_pkg::irq_t  irq_level
);

    // A stalled result holds
    `USTMR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(rdata) && $stable(irq_pulse) && $stable(irq_level))

    // Every pulsed interrupt is also active in the level after the step
    `USTMR_ASSERT_NOW(a_pulse_in_level, clk, rst_n, out_valid,
        (irq_pulse & ~irq_level) == '0)

    // A level bit that comes up between back-to-back results was pulsed
    `USTMR_ASSERT_NEXT(a_rise_pulsed, clk, rst_n, out_valid && !out_stall,
        !out_valid || ((irq_level & ~$past(irq_level) & ~irq_pulse) == '0))

    // With the result register empty the input side never stalls
    `USTMR_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall)

endmodule

bind us_timer_with_four_alarms ustmr_checker u_ustmr_checker (.*);

`default_nettype wire

// ===== dv/ustmr_tb_pkg.sv =====
// Scoreboard for the microsecond timer bench: a shadow copy of the timer
// state that predicts every result item. Depends on ustmr_pkg.
`timescale 1ns / 1ps

package ustmr_tb_pkg;

    typedef struct packed {
        ustmr_pkg::word_t rdata;
        ustmr_pkg::irq_t  pulse;
        ustmr_pkg::irq_t  level;
    } bus_result_t;

    class ustmr_scoreboard;

        logic [ustmr_pkg::TIME_W-1:0] count = '0;
        ustmr_pkg::word_t alarm_tgt [ustmr_pkg::ALARM_MAX] = '{default: '0};
        ustmr_pkg::irq_t  armed  = '0;
        ustmr_pkg::irq_t  raw    = '0;
        ustmr_pkg::irq_t  inte   = '0;
        ustmr_pkg::irq_t  intf   = '0;
        logic             paused = 1'b0;

        bus_result_t bus_responses [$];
        int unsigned fails   = 0;
        int unsigned n_read  = 0;
        int unsigned n_write = 0;
        int unsigned n_tick  = 0;
        int unsigned n_fired = 0;

        function ustmr_pkg::irq_t status();
            return (raw | intf) & inte;
        endfunction

        // -1 when the offset is not an aligned alarm slot
        function int alarm_index(ustmr_pkg::off_t off);
            if (off < ustmr_pkg::OFF_ALARM0
                || off > ustmr_pkg::OFF_ALARM0
                         + ustmr_pkg::ALARM_STRIDE * (ustmr_pkg::ALARM_MAX - 1)
                || off[1:0] != 2'b00)
                return -1;
            return (int'(off) - int'(ustmr_pkg::OFF_ALARM0)) / ustmr_pkg::ALARM_STRIDE;
        endfunction

        function ustmr_pkg::word_t read_reg(ustmr_pkg::off_t off);
            int idx;
            idx = alarm_index(off);
            if (idx >= 0)
                return alarm_tgt[idx];
            case (off)
                ustmr_pkg::OFF_TIMEHR:
                    return (raw != '0) ? ustmr_pkg::word_t'(1) : count[63:32];
                ustmr_pkg::OFF_TIMELR:   return count[31:0];
                ustmr_pkg::OFF_ARMED:    return ustmr_pkg::word_t'(armed);
                ustmr_pkg::OFF_TIMERAWH: return count[63:32];
                ustmr_pkg::OFF_TIMERAWL: return count[31:0];
                ustmr_pkg::OFF_PAUSE:    return ustmr_pkg::word_t'(paused);
                ustmr_pkg::OFF_INTR:     return ustmr_pkg::word_t'(raw);
                ustmr_pkg::OFF_INTE:     return ustmr_pkg::word_t'(inte);
                ustmr_pkg::OFF_INTF:     return ustmr_pkg::word_t'(intf);
                ustmr_pkg::OFF_INTS:     return ustmr_pkg::word_t'(status());
                default:                 return '0;
            endcase
        endfunction

        function void note_item(ustmr_pkg::cmd_t cmd, ustmr_pkg::off_t off,
                                ustmr_pkg::kind_t kind, ustmr_pkg::word_t wd,
                                ustmr_pkg::word_t us);
            bus_result_t      r;
            ustmr_pkg::word_t v;
            ustmr_pkg::word_t diff;
            int               idx;
            int               i;
            r.rdata = '0;
            r.pulse = '0;
            case (cmd)
                ustmr_pkg::CMD_READ:
                begin
                    n_read++;
                    r.rdata = read_reg(off);
                end
                ustmr_pkg::CMD_WRITE:
                begin
                    n_write++;
                    case (kind)
                        ustmr_pkg::ALIAS_XOR: v = read_reg(off) ^ wd;
                        ustmr_pkg::ALIAS_SET: v = read_reg(off) | wd;
                        ustmr_pkg::ALIAS_CLR: v = read_reg(off) & ~wd;
                        default:              v = wd;
                    endcase
                    idx = alarm_index(off);
                    if (idx >= 0)
                    begin
                        alarm_tgt[idx] = v;
                        armed[idx] = 1'b1;
                    end
                    else
                    begin
                        case (off)
                            ustmr_pkg::OFF_TIMEHW: count[63:32] = v;
                            ustmr_pkg::OFF_TIMELW: count[31:0] = v;
                            ustmr_pkg::OFF_ARMED:
                                armed = armed & ~v[ustmr_pkg::IRQ_W-1:0];
                            ustmr_pkg::OFF_PAUSE:  paused = v[0];
                            ustmr_pkg::OFF_INTR:
                                raw = raw & ~v[ustmr_pkg::IRQ_W-1:0];
                            // enable and force re-signal the whole active status
                            ustmr_pkg::OFF_INTE:
                            begin
                                inte = v[ustmr_pkg::IRQ_W-1:0];
                                r.pulse = status();
                            end
                            ustmr_pkg::OFF_INTF:
                            begin
                                intf = v[ustmr_pkg::IRQ_W-1:0];
                                r.pulse = status();
                            end
                            default: ;
                        endcase
                    end
                end
                ustmr_pkg::CMD_TICK:
                begin
                    n_tick++;
                    if (!paused && us != '0)
                    begin
                        count = count + {32'd0, us};
                        for (i = 0; i < ustmr_pkg::ALARM_MAX; i++)
                        begin
                            diff = count[31:0] - alarm_tgt[i];
                            if (armed[i] && !diff[31])
                            begin
                                n_fired++;
                                raw[i] = 1'b1;
                                armed[i] = 1'b0;
                                r.pulse[i] = inte[i];
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.level = status();
            bus_responses.push_back(r);
        endfunction

        function void check_result(ustmr_pkg::word_t rd, ustmr_pkg::irq_t pulse,
                                   ustmr_pkg::irq_t level);
            bus_result_t e;
            if (bus_responses.size() == 0)
            begin
                $error("result item with nothing outstanding: rdata=%h", rd);
                fails++;
                return;
            end
            e = bus_responses.pop_front();
            if (rd !== e.rdata)
            begin
                $error("rdata: expected %h, got %h", e.rdata, rd);
                fails++;
            end
            if (pulse !== e.pulse)
            begin
                $error("irq_pulse: expected %h, got %h", e.pulse, pulse);
                fails++;
            end
            if (level !== e.level)
            begin
                $error("irq_level: expected %h, got %h", e.level, level);
                fails++;
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_us_timer_with_four_alarms.sv =====
// Top of the microsecond timer bench: clock, reset, item driver, random
// result stall and watchdog. Depends on ustmr_pkg, ustmr_tb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_us_timer_with_four_alarms;

    localparam ustmr_pkg::cmd_t CMD_NONE    = 2'd3;
    localparam int unsigned     QUIET_LIMIT = 1000;
    localparam int unsigned     DRAIN_WAIT  = 4;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    ustmr_pkg::cmd_t  cmd;
    ustmr_pkg::off_t  reg_offset;
    ustmr_pkg::kind_t alias_kind;
    ustmr_pkg::word_t wdata;
    ustmr_pkg::word_t tick_us;
    logic             out_valid;
    logic             out_stall = 1'b0;
    ustmr_pkg::word_t rdata;
    ustmr_pkg::irq_t  irq_pulse;
    ustmr_pkg::irq_t  irq_level;

    ustmr_tb_pkg::ustmr_scoreboard sb;
    int unsigned     send_gap_pct = 0;
    int unsigned     stall_pct    = 0;
    int unsigned     quiet_cycles = 0;

    us_timer_with_four_alarms DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .reg_offset (reg_offset),
        .alias_kind (alias_kind),
        .wdata      (wdata),
        .tick_us    (tick_us),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rdata      (rdata),
        .irq_pulse  (irq_pulse),
        .irq_level  (irq_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // note accepted items, check results, and end a hung run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(cmd, reg_offset, alias_kind, wdata, tick_us);
            if (out_valid && !out_stall)
                sb.check_result(rdata, irq_pulse, irq_level);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(ustmr_pkg::cmd_t c, ustmr_pkg::off_t o, ustmr_pkg::kind_t k,
                        ustmr_pkg::word_t wd, ustmr_pkg::word_t us);
        // idle the sender for a random share of the cycles
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        reg_offset <= o;
        alias_kind <= k;
        wdata      <= wd;
        tick_us    <= us;
        do @(posedge clk); while (in_stall);
    endtask

    // hold off new items until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.bus_responses.size() != 0);
    endtask

    task automatic send_random();
        ustmr_pkg::cmd_t  c;
        ustmr_pkg::off_t  o;
        ustmr_pkg::kind_t k;
        ustmr_pkg::word_t wd;
        ustmr_pkg::word_t us;
        int unsigned      pick;
        pick = $urandom_range(99);
        if (pick < 34)
            c = ustmr_pkg::CMD_READ;
        else if (pick < 70)
            c = ustmr_pkg::CMD_WRITE;
        else if (pick < 98)
            c = ustmr_pkg::CMD_TICK;
        else
            c = CMD_NONE;
        if ($urandom_range(9) == 0)
            o = ustmr_pkg::off_t'($urandom_range(255));
        else
            o = ustmr_pkg::off_t'(ustmr_pkg::ALARM_STRIDE * $urandom_range(18));
        k = ustmr_pkg::kind_t'($urandom_range(3));
        case ($urandom_range(3))
            0:       wd = $urandom_range(15);
            1:       wd = '1;
            default: wd = $urandom;
        endcase
        us = $urandom;
        if (c == ustmr_pkg::CMD_WRITE && sb.alarm_index(o) >= 0 && $urandom_range(3) != 0)
        begin
            // target shortly ahead of the count so that later ticks reach it
            k  = ustmr_pkg::ALIAS_PLAIN;
            wd = sb.count[31:0] + $urandom_range(2000);
        end
        if (c == ustmr_pkg::CMD_WRITE && o == ustmr_pkg::OFF_PAUSE)
            wd = ustmr_pkg::word_t'($urandom_range(3) == 0);
        if (c == ustmr_pkg::CMD_TICK)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                us = '0;
            else if (pick < 8)
                us = $urandom_range(600, 1);
        end
        send(c, o, k, wd, us);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = ustmr_pkg::CMD_READ;
        reg_offset = ustmr_pkg::OFF_TIMEHW;
        alias_kind = ustmr_pkg::ALIAS_PLAIN;
        wdata      = '0;
        tick_us    = '0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 32;
        stall_pct    = 53;
        send(ustmr_pkg::CMD_READ, ustmr_pkg::OFF_TIMEHW, ustmr_pkg::ALIAS_PLAIN, 0, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_TIMEHW, ustmr_pkg::ALIAS_PLAIN,
             32'hFFFF_FFFF, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_TIMELW, ustmr_pkg::ALIAS_PLAIN,
             32'hFFFF_FFF0, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_ALARM0, ustmr_pkg::ALIAS_PLAIN, 32'h5, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_ALARM0 + 8'd4, ustmr_pkg::ALIAS_SET,
             32'h8000_0000, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_INTE, ustmr_pkg::ALIAS_PLAIN, 32'h5, 0);
        // count wraps past 2^64 and alarm 0 expires with its enable set
        send(ustmr_pkg::CMD_TICK, ustmr_pkg::OFF_TIMEHW, ustmr_pkg::ALIAS_XOR,
             32'hFFFF_FFFF, 32'h20);
        send(ustmr_pkg::CMD_READ, ustmr_pkg::OFF_TIMEHR, ustmr_pkg::ALIAS_CLR,
             32'hFFFF_FFFF, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_INTR, ustmr_pkg::ALIAS_PLAIN,
             32'hFFFF_FFFF, 0);
        send(ustmr_pkg::CMD_READ, ustmr_pkg::OFF_TIMEHR, ustmr_pkg::ALIAS_PLAIN, 0, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_ALARM0 + 8'd12, ustmr_pkg::ALIAS_PLAIN,
             32'h30, 0);
        // alarm 3 expires with its enable clear
        send(ustmr_pkg::CMD_TICK, ustmr_pkg::OFF_INTS, ustmr_pkg::ALIAS_PLAIN, 0, 32'h40);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_INTF, ustmr_pkg::ALIAS_XOR, 32'hA, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_INTE, ustmr_pkg::ALIAS_XOR, 32'hF, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_INTE, ustmr_pkg::ALIAS_CLR, 32'h2, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_PAUSE, ustmr_pkg::ALIAS_PLAIN, 32'h1, 0);
        send(ustmr_pkg::CMD_TICK, ustmr_pkg::OFF_PAUSE, ustmr_pkg::ALIAS_PLAIN, 0,
             32'hFFFF_FFFF);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_PAUSE, ustmr_pkg::ALIAS_CLR,
             32'hFFFF_FFFF, 0);
        send(ustmr_pkg::CMD_TICK, ustmr_pkg::OFF_PAUSE, ustmr_pkg::ALIAS_PLAIN, 0, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_TIMEHR, ustmr_pkg::ALIAS_PLAIN,
             32'h1234, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_INTS, ustmr_pkg::ALIAS_SET, 32'hF, 0);
        send(ustmr_pkg::CMD_WRITE, ustmr_pkg::OFF_ARMED, ustmr_pkg::ALIAS_PLAIN, 32'hF, 0);
        send(ustmr_pkg::CMD_READ, ustmr_pkg::OFF_ALARM0 + 8'd13, ustmr_pkg::ALIAS_PLAIN,
             0, 0);
        send(ustmr_pkg::CMD_WRITE, 8'hFF, ustmr_pkg::ALIAS_PLAIN, 32'hFFFF_FFFF, 0);
        send(CMD_NONE, ustmr_pkg::OFF_INTS, ustmr_pkg::ALIAS_CLR, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
        send(ustmr_pkg::CMD_READ, ustmr_pkg::OFF_INTS, ustmr_pkg::ALIAS_SET, 0, 0);

        repeat (360) send_random();
        drain();
        send_gap_pct = 53;
        stall_pct    = 32;
        repeat (360) send_random();
        drain();
        send_gap_pct = 0;
        stall_pct    = 0;
        repeat (360) send_random();
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.bus_responses.size() != 0)
        begin
            $error("result items missing: %0d outstanding", sb.bus_responses.size());
            sb.fails++;
        end

        $display("Covered %0d reads, %0d writes and %0d ticks, with %0d alarm expiries,",
                 sb.n_read, sb.n_write, sb.n_tick, sb.n_fired);
        $display("under three mixes of sender gaps and result stalls.");
        if (sb.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
